// ===== src/hbdt_pkg.sv =====
// ----------------------------------------------------------------------------
// hbdt_pkg - shared types and constants for the Hall baseline drift tracker
// Per-pad state record, request codes and configuration register indexes.
// ----------------------------------------------------------------------------
package hbdt_pkg;

    // request kinds carried in s_tuser
    localparam logic [1:0] REQ_BACKGROUND = 2'd0;
    localparam logic [1:0] REQ_PRIORITY   = 2'd1;
    localparam logic [1:0] REQ_CAPTURE    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_PAD_ENABLE = 2'd0;
    localparam logic [1:0] REG_NOISE_THR  = 2'd1;
    localparam logic [1:0] REG_DWELL_MS   = 2'd2;
    localparam logic [1:0] REG_SLEW_SHIFT = 2'd3;

    localparam int MASK_W = 24;

    localparam logic [MASK_W-1:0] PAD_ENABLE_RST = '0;
    localparam logic [15:0]       NOISE_THR_RST  = 16'd8;
    localparam logic [31:0]       DWELL_MS_RST   = 32'd400;
    localparam logic [3:0]        SLEW_SHIFT_RST = 4'd7;

    typedef struct packed {
        logic signed [15:0] baseline_z;
        logic signed [15:0] last_stable_z;
        logic [31:0]        stable_since;
        logic               ref_valid;
        logic signed [15:0] sample_z;
        logic               sample_valid;
    } pad_state_t;

endpackage

// ===== src/hbdt_state_mem.sv =====
// ----------------------------------------------------------------------------
// hbdt_state_mem - per-pad state memory
// One write port, one read port with registered data. Entry valid bits
// cleared at reset make never-written entries read back as all zero.
// ----------------------------------------------------------------------------
module hbdt_state_mem
    import hbdt_pkg::*;
#(
    parameter int NUM_PADS = 24,
    parameter int ADDR_W   = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output pad_state_t        rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pad_state_t        wr_data
);

    pad_state_t          mem [NUM_PADS];
    logic [NUM_PADS-1:0] vld_reg;
    pad_state_t          rd_data_reg;
    logic                rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== src/hall_baseline_drift_tracker.sv =====
// ----------------------------------------------------------------------------
// hall_baseline_drift_tracker - per-pad Hall Z baseline tracker
// Gated slow drift compensation of each pad's Z baseline.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) takes one sample or capture request per transfer;
//   s_tuser holds the request kind, s_tdata the pad, reading and timestamp.
//   Master channel (m_*) returns exactly one result per request: depth,
//   baseline after the request, nudge flag and stored sample validity.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
// Sequencing:
//   Per-pad state sits in a memory with a registered read port. A request
//   is read, updated in two compute steps and written back before the next
//   request is read: the block takes no new request until the result of the
//   last one has gone into the output register, and the read-modify-write
//   sequence of the state memory is what holds the next request back.
// Reset and stalls:
//   Reset clears all pad state (valid bits per entry, no clearing pass) and
//   loads register defaults. A stalled result holds in the output register;
//   one more request may be computed meanwhile and waits until it drains.
// ----------------------------------------------------------------------------
module hall_baseline_drift_tracker
    import hbdt_pkg::*;
#(
    parameter int NUM_PADS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // [4:0] pad, [20:5] z_reading, [21] read_ok, [22] touched,
    // [54:23] time_ms, [55] zero
    input  logic [55:0] s_tdata,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] depth, [31:16] baseline_out, [32] nudged, [33] sample_ok,
    // [39:34] zero
    output logic [39:0] m_tdata
);

    localparam int ADDR_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_NUDGE = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    // configuration registers
    logic [MASK_W-1:0] pad_enable_reg;
    logic [15:0]       noise_thr_reg;
    logic [31:0]       dwell_ms_reg;
    logic [3:0]        slew_shift_reg;

    logic [1:0] state_reg, state_next;

    // input unpack
    logic [4:0]         in_pad;
    logic               in_range, in_enabled, s_xfer;

    // latched request
    logic [1:0]         req_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic signed [15:0] z_reg;
    logic               ok_reg, touched_reg;
    logic [31:0]        time_reg;
    logic               en_reg, range_reg;

    // compute step one
    pad_state_t         rd_ent;
    pad_state_t         ent_next, ent_reg;
    logic               upd_next, upd_reg;
    logic               cand_next, cand_reg;
    logic [15:0]        gap_mag_next, gap_mag_reg;
    logic               gap_neg_next, gap_neg_reg;
    logic signed [16:0] step_diff, gap_diff;
    logic [15:0]        step_mag;
    logic [31:0]        elapsed;

    // compute step two
    pad_state_t         wb_ent;
    logic [15:0]        nudge_mag, nudge_shr;
    logic signed [16:0] nudge_sum;
    logic               nudge_now;
    logic               nudged_reg;

    // result
    logic signed [16:0] depth_diff;
    logic [15:0]        depth_val;
    logic               out_load;
    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_enable_reg <= PAD_ENABLE_RST;
            noise_thr_reg  <= NOISE_THR_RST;
            dwell_ms_reg   <= DWELL_MS_RST;
            slew_shift_reg <= SLEW_SHIFT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PAD_ENABLE: pad_enable_reg <= cfg_data[MASK_W-1:0];
                REG_NOISE_THR:  noise_thr_reg  <= cfg_data[15:0];
                REG_DWELL_MS:   dwell_ms_reg   <= cfg_data;
                REG_SLEW_SHIFT: slew_shift_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---------------- input side ----------------
    assign in_pad     = s_tdata[4:0];
    assign in_range   = 32'(in_pad) < NUM_PADS;
    assign in_enabled = in_range && (32'(in_pad) < MASK_W) && pad_enable_reg[in_pad];
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_xfer     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            req_reg     <= s_tuser;
            addr_reg    <= ADDR_W'(in_pad);
            z_reg       <= s_tdata[20:5];
            ok_reg      <= s_tdata[21];
            touched_reg <= s_tdata[22];
            time_reg    <= s_tdata[54:23];
            en_reg      <= in_enabled;
            range_reg   <= in_range;
        end
    end

    hbdt_state_mem #(
        .NUM_PADS (NUM_PADS),
        .ADDR_W   (ADDR_W)
    ) u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_xfer && in_range),
        .rd_addr (ADDR_W'(in_pad)),
        .rd_data (rd_ent),
        .wr_en   (state_reg == ST_NUDGE && upd_reg),
        .wr_addr (addr_reg),
        .wr_data (wb_ent)
    );

    // ---------------- step one: sample store, tracker decisions ----------------
    assign step_diff = 17'(z_reg) - 17'(rd_ent.last_stable_z);
    assign step_mag  = step_diff[16] ? 16'(-step_diff) : step_diff[15:0];
    assign elapsed   = time_reg - rd_ent.stable_since;
    assign gap_diff  = 17'(z_reg) - 17'(rd_ent.baseline_z);

    always_comb begin
        ent_next     = rd_ent;
        upd_next     = en_reg && (req_reg == REQ_BACKGROUND || req_reg == REQ_PRIORITY ||
                                  req_reg == REQ_CAPTURE);
        cand_next    = 1'b0;
        gap_neg_next = gap_diff[16];
        gap_mag_next = gap_diff[16] ? 16'(-gap_diff) : gap_diff[15:0];
        if (upd_next) begin
            ent_next.sample_valid = ok_reg;
            if (ok_reg) begin
                ent_next.sample_z = z_reg;
                if (req_reg == REQ_CAPTURE) begin
                    ent_next.baseline_z    = z_reg;
                    ent_next.ref_valid     = 1'b0;
                    ent_next.last_stable_z = '0;
                    ent_next.stable_since  = '0;
                end else if (req_reg == REQ_BACKGROUND) begin
                    if (touched_reg) begin
                        ent_next.ref_valid     = 1'b0;
                        ent_next.last_stable_z = '0;
                        ent_next.stable_since  = '0;
                    end else if (!rd_ent.ref_valid) begin
                        ent_next.ref_valid     = 1'b1;
                        ent_next.last_stable_z = z_reg;
                        ent_next.stable_since  = time_reg;
                    end else begin
                        ent_next.last_stable_z = z_reg;
                        if (step_mag > noise_thr_reg) begin
                            ent_next.stable_since = time_reg;
                        end else if (elapsed >= dwell_ms_reg) begin
                            cand_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CALC) begin
            ent_reg     <= ent_next;
            cand_reg    <= cand_next;
            gap_mag_reg <= gap_mag_next;
            gap_neg_reg <= gap_neg_next;
        end
    end

    // ---------------- step two: drift nudge and write-back ----------------
    assign nudge_shr = gap_mag_reg >> slew_shift_reg;
    assign nudge_mag = (nudge_shr == '0) ? 16'd1 : nudge_shr;
    assign nudge_now = cand_reg && (gap_mag_reg != '0);
    assign nudge_sum = gap_neg_reg ? 17'(ent_reg.baseline_z) - 17'(nudge_mag)
                                   : 17'(ent_reg.baseline_z) + 17'(nudge_mag);

    always_comb begin
        wb_ent = ent_reg;
        if (nudge_now) begin
            // nudge moves toward the reading, so the sum stays in 16 bits
            wb_ent.baseline_z = nudge_sum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_NUDGE) begin
            upd_reg <= upd_reg;
        end else if (state_reg == ST_CALC) begin
            upd_reg <= upd_next;
        end
    end

    pad_state_t res_ent_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_NUDGE) begin
            res_ent_reg <= wb_ent;
            nudged_reg  <= nudge_now;
        end
    end

    // ---------------- result ----------------
    assign depth_diff = 17'(res_ent_reg.sample_z) - 17'(res_ent_reg.baseline_z);
    assign depth_val  = (en_reg && res_ent_reg.sample_valid)
                      ? (depth_diff[16] ? 16'(-depth_diff) : depth_diff[15:0]) : 16'd0;
    assign out_load   = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {6'd0,
                            range_reg && res_ent_reg.sample_valid,
                            nudged_reg,
                            range_reg ? res_ent_reg.baseline_z : 16'sd0,
                            depth_val};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_xfer) state_next = ST_CALC;
            ST_CALC:  state_next = ST_NUDGE;
            ST_NUDGE: state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in flight");

    a_load_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_depth_needs_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[15:0] != 16'd0) |-> m_tdata[33])
        else $error("nonzero depth without a valid sample");

    a_nudge_needs_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[33])
        else $error("nudge reported without a valid sample");
`endif

endmodule
